// ----- rtl/core/sfc_pkg.sv -----
// Package for the sample format converter: codes, constants and the result record.
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int WORD_W  = 24;
    localparam int BYTES_W = 32;

    // Direction codes
    localparam logic FUNC_PACK   = 1'b0;
    localparam logic FUNC_UNPACK = 1'b1;

    // Sample format codes
    localparam logic [2:0] FMT_OFFSET8 = 3'd0;  // 8-bit offset binary
    localparam logic [2:0] FMT_UPPER16 = 3'd1;  // upper 16 bits
    localparam logic [2:0] FMT_MSB24   = 3'd2;  // 24 bits MSB-aligned in 32
    localparam logic [2:0] FMT_PAIR32  = 3'd3;  // 32 bits in a word pair
    localparam logic [2:0] FMT_LSB24   = 3'd6;  // 24 bits LSB-aligned in 32

    localparam logic [WORD_W-1:0] SIGN_BIT  = 24'h80_0000;
    localparam logic [WORD_W:0]   ROUND_BIT = 25'h000_8000;
    localparam logic [7:0]        BYTE_SIGN = 8'h80;
    localparam logic [7:0]        SAT_MAX   = 8'hFF;

    localparam logic [2:0] NBYTES_1 = 3'd1;
    localparam logic [2:0] NBYTES_2 = 3'd2;
    localparam logic [2:0] NBYTES_4 = 3'd4;
    localparam logic [1:0] NWORDS_1 = 2'd1;
    localparam logic [1:0] NWORDS_2 = 2'd2;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes_out;
        logic [2:0]         byte_count;
        logic [WORD_W-1:0]  word_out_first;
        logic [WORD_W-1:0]  word_out_second;
        logic [1:0]         word_count;
        logic               format_invalid;
    } t_result;

endpackage

// ----- rtl/core/sfc_convert.sv -----
// Combinational pack/unpack datapath for one transaction.
`timescale 1ns / 1ps

module sfc_convert (
    input  logic                       i_func,
    input  logic [2:0]                 i_sample_format,
    input  logic [sfc_pkg::WORD_W-1:0] i_word_first,
    input  logic [sfc_pkg::WORD_W-1:0] i_word_second,
    input  logic [sfc_pkg::BYTES_W-1:0] i_bytes_in,
    output sfc_pkg::t_result           o_result
);

    logic [sfc_pkg::WORD_W:0]   rounded;
    logic [7:0]                 offset8;

    // bias to unsigned, round on bit 15, clip the 256 case
    always_comb begin
        rounded = {1'b0, i_word_first ^ sfc_pkg::SIGN_BIT} + sfc_pkg::ROUND_BIT;
        offset8 = rounded[sfc_pkg::WORD_W] ? sfc_pkg::SAT_MAX : rounded[23:16];
    end

    always_comb begin
        o_result = '0;
        if (i_func == sfc_pkg::FUNC_PACK) begin
            case (i_sample_format)
                sfc_pkg::FMT_OFFSET8: begin
                    o_result.bytes_out  = {24'd0, offset8};
                    o_result.byte_count = sfc_pkg::NBYTES_1;
                end
                sfc_pkg::FMT_UPPER16: begin
                    o_result.bytes_out  = {16'd0, i_word_first[23:8]};
                    o_result.byte_count = sfc_pkg::NBYTES_2;
                end
                sfc_pkg::FMT_MSB24: begin
                    o_result.bytes_out  = {i_word_first, 8'd0};
                    o_result.byte_count = sfc_pkg::NBYTES_4;
                end
                sfc_pkg::FMT_PAIR32: begin
                    o_result.bytes_out  = {i_word_second, i_word_first[23:16]};
                    o_result.byte_count = sfc_pkg::NBYTES_4;
                end
                sfc_pkg::FMT_LSB24: begin
                    o_result.bytes_out  = {8'd0, i_word_first};
                    o_result.byte_count = sfc_pkg::NBYTES_4;
                end
                default: begin
                    o_result.format_invalid = 1'b1;
                end
            endcase
        end else begin
            case (i_sample_format)
                sfc_pkg::FMT_OFFSET8: begin
                    o_result.word_out_first = {i_bytes_in[7:0] ^ sfc_pkg::BYTE_SIGN, 16'd0};
                    o_result.word_count     = sfc_pkg::NWORDS_1;
                end
                sfc_pkg::FMT_UPPER16: begin
                    o_result.word_out_first = {i_bytes_in[15:0], 8'd0};
                    o_result.word_count     = sfc_pkg::NWORDS_1;
                end
                sfc_pkg::FMT_MSB24: begin
                    o_result.word_out_first = i_bytes_in[31:8];
                    o_result.word_count     = sfc_pkg::NWORDS_1;
                end
                sfc_pkg::FMT_PAIR32: begin
                    o_result.word_out_first  = {i_bytes_in[7:0], 16'd0};
                    o_result.word_out_second = i_bytes_in[31:8];
                    o_result.word_count      = sfc_pkg::NWORDS_2;
                end
                sfc_pkg::FMT_LSB24: begin
                    o_result.word_out_first = i_bytes_in[23:0];
                    o_result.word_count     = sfc_pkg::NWORDS_1;
                end
                default: begin
                    o_result.format_invalid = 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/dsp_sample_format_convert.sv -----
// Top level of the DSP sample format converter (24-bit words <-> buffer bytes).
// Usage:
//   Command channel: drive the fields and raise start; a transaction is taken
//   at a rising edge with start high and busy low. busy is only high during
//   reset and in the cycle after it, so a new transaction can be issued on every clock.
//   Result channel: o_valid marks one cycle in which the result fields hold
//   one result; it is taken at the edge that ends that cycle. There is no
//   back-pressure: the receiver must take every result as it comes.
// Datapath: the command is captured in an input register at the accepting
//   edge, converted by shallow logic, and captured in the result register
//   that drives the ports.
// Throughput: 1 transaction per cycle while busy is low; the valid flags of
//   both stages advance every cycle and nothing in the datapath iterates.
// Reset: synchronous, active low. Clears the valid flags of both stages so
//   no result is produced for anything in flight; busy is high for one cycle
//   after reset is released. Result fields hold their last value between
//   strobes and are only meaningful while o_valid is high.
// Pack results carry zero word fields; unpack results carry zero byte
// fields; rejected formats (4, 5, 7) set o_format_invalid with all else 0.
`timescale 1ns / 1ps

module dsp_sample_format_convert (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [2:0]                  i_sample_format,
    input  logic [sfc_pkg::WORD_W-1:0]  i_word_first,
    input  logic [sfc_pkg::WORD_W-1:0]  i_word_second,
    input  logic [sfc_pkg::BYTES_W-1:0] i_bytes_in,
    output logic                        o_valid,
    output logic [sfc_pkg::BYTES_W-1:0] o_bytes_out,
    output logic [2:0]                  o_byte_count,
    output logic [sfc_pkg::WORD_W-1:0]  o_word_out_first,
    output logic [sfc_pkg::WORD_W-1:0]  o_word_out_second,
    output logic [1:0]                  o_word_count,
    output logic                        o_format_invalid
);

    // control
    logic r_busy;
    logic r_in_vld;
    logic r_out_vld;
    logic n_in_vld;

    // input stage payload
    logic                        r_func;
    logic [2:0]                  r_sample_format;
    logic [sfc_pkg::WORD_W-1:0]  r_word_first;
    logic [sfc_pkg::WORD_W-1:0]  r_word_second;
    logic [sfc_pkg::BYTES_W-1:0] r_bytes_in;

    // result stage
    sfc_pkg::t_result n_result;
    sfc_pkg::t_result r_result;

    assign n_in_vld = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_in_vld  <= n_in_vld;
            r_out_vld <= r_in_vld;
        end
    end

    // payload capture: only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_func          <= i_func;
            r_sample_format <= i_sample_format;
            r_word_first    <= i_word_first;
            r_word_second   <= i_word_second;
            r_bytes_in      <= i_bytes_in;
        end
    end

    sfc_convert u_convert (
        .i_func          (r_func),
        .i_sample_format (r_sample_format),
        .i_word_first    (r_word_first),
        .i_word_second   (r_word_second),
        .i_bytes_in      (r_bytes_in),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign busy              = r_busy;
    assign o_valid           = r_out_vld;
    assign o_bytes_out       = r_result.bytes_out;
    assign o_byte_count      = r_result.byte_count;
    assign o_word_out_first  = r_result.word_out_first;
    assign o_word_out_second = r_result.word_out_second;
    assign o_word_count      = r_result.word_count;
    assign o_format_invalid  = r_result.format_invalid;

`ifndef SYNTH
    // every captured transaction yields a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_valid)
        else $error("captured transaction produced no result");

    // a strobe only follows a captured transaction
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_vld))
        else $error("result strobe without a transaction");

    // rejected format clears every other field
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_format_invalid) |->
            (o_bytes_out == '0 && o_byte_count == '0 && o_word_out_first == '0 &&
             o_word_out_second == '0 && o_word_count == '0))
        else $error("invalid format result has nonzero fields");

    // a valid result is either a pack or an unpack, never both
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_format_invalid) |-> ((o_byte_count == '0) != (o_word_count == '0)))
        else $error("result mixes pack and unpack counts");
`endif

endmodule
